FILE: rtl/bfs_path_finder_defines.svh
// Assertion macros used by the path finder datapath.
`ifndef BFS_PATH_FINDER_DEFINES_SVH
`define BFS_PATH_FINDER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define BPF_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a trigger implies a condition on the same edge.
`define BPF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a trigger implies a condition on the next edge.
`define BPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/bpf_pkg.sv
// Types, codes and helper functions for the breadth-first path finder.
package bpf_pkg;

  localparam int VW     = 6;
  localparam int ROW_W  = 64;
  localparam int TALLYW = 12;
  localparam int CNTW   = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOPATH  = 2'd1,
    ST_INVALID = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PV_ZERO = 2'd0,
    PV_CUR  = 2'd1,
    PV_SRC  = 2'd2,
    PV_RSVD = 2'd3
  } pv_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EDGE_RA,
    S_EDGE_A,
    S_EDGE_RB,
    S_EDGE_B,
    S_RESULT,
    S_BFS_INIT,
    S_BFS_DEQ,
    S_BFS_X,
    S_BFS_ROW,
    S_BFS_SCAN,
    S_PATH_INIT,
    S_PATH_CHECK,
    S_PATH_WAIT,
    S_NOPATH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    edge_read_a;
    logic    edge_write_a;
    logic    edge_read_b;
    logic    edge_write_b;
    logic    bfs_init;
    logic    deq_read;
    logic    load_x;
    logic    load_cand;
    logic    scan_step;
    logic    path_init;
    logic    path_step;
    logic    load_out;
    status_t out_status;
    pv_sel_t out_pv;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic    skip;
    op_t     op;
    status_t res_status;
    logic    edge_change;
    logic    queue_ready;
    logic    cand_zero;
    logic    hit_dst;
    logic    path_more;
    logic    out_free;
  } sts_t;

  function automatic logic [VW-1:0] lowest_bit(input logic [ROW_W-1:0] word);
    logic [VW-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (word[i]) idx = VW'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/bfs_path_finder.sv
// Top level of the breadth-first path finder.
// Holds an undirected graph of up to MAX_VERTICES vertices as an adjacency
// bit matrix. Input transactions arrive on s_axis: insert edge, remove edge,
// find path or no operation. Results leave on m_axis: one per transaction,
// but one per path vertex (destination back to source) for a found path;
// tlast marks the final result of each input transaction.
// cfg_valid/cfg_data write the vertex count; write only while idle.
// An edge operation reads the first vertex's row and, if the edge changes,
// rewrites it and then reads and rewrites the second vertex's row. A path
// query reads one adjacency row per dequeued vertex, scans its neighbors
// not yet dequeued, then emits the path vertices from the parent table.
// One input transaction is worked at a time; the next is accepted while
// the final result still waits in the output register.
// Reset clears the graph, the edge count and sets the vertex count to 64.
// A stalled m_axis_tready holds the result register and holds the state
// machine before its next result load.
module bfs_path_finder #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // operation[1:0], first_vertex[7:2], second_vertex[13:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0], path_vertex[7:2], edge_total[19:8]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import bpf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpf_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: rtl/bpf_ctrl.sv
// Control state machine for the breadth-first path finder.
module bpf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpf_pkg::sts_t sts,
  output bpf_pkg::cmd_t cmd
);
  import bpf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        priority if (sts.skip)           state_next = S_RESULT;
        else if (sts.op == OP_FIND)      state_next = S_BFS_INIT;
        else                             state_next = S_EDGE_RA;
      end
      S_EDGE_RA:    state_next = S_EDGE_A;
      S_EDGE_A:     state_next = sts.edge_change ? S_EDGE_RB : S_RESULT;
      S_EDGE_RB:    state_next = S_EDGE_B;
      S_EDGE_B:     state_next = S_RESULT;
      S_RESULT:     if (sts.out_free) state_next = S_IDLE;
      S_BFS_INIT:   state_next = S_BFS_DEQ;
      S_BFS_DEQ:    state_next = sts.queue_ready ? S_BFS_X : S_NOPATH;
      S_BFS_X:      state_next = S_BFS_ROW;
      S_BFS_ROW:    state_next = S_BFS_SCAN;
      S_BFS_SCAN: begin
        priority if (sts.cand_zero) state_next = S_BFS_DEQ;
        else if (sts.hit_dst)       state_next = S_PATH_INIT;
        else                        state_next = S_BFS_SCAN;
      end
      S_PATH_INIT:  state_next = S_PATH_CHECK;
      S_PATH_CHECK: if (sts.out_free) state_next = sts.path_more ? S_PATH_WAIT : S_IDLE;
      S_PATH_WAIT:  if (sts.out_free) state_next = S_PATH_CHECK;
      S_NOPATH:     if (sts.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = ST_OK;
    cmd.out_pv     = PV_ZERO;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EDGE_RA:   cmd.edge_read_a = 1'b1;
      S_EDGE_A:    cmd.edge_write_a = sts.edge_change;
      S_EDGE_RB:   cmd.edge_read_b = 1'b1;
      S_EDGE_B:    cmd.edge_write_b = 1'b1;
      S_RESULT: begin
        cmd.load_out   = sts.out_free;
        cmd.out_status = sts.res_status;
        cmd.out_last   = 1'b1;
      end
      S_BFS_INIT:  cmd.bfs_init = 1'b1;
      S_BFS_DEQ:   cmd.deq_read = sts.queue_ready;
      S_BFS_X:     cmd.load_x = 1'b1;
      S_BFS_ROW:   cmd.load_cand = 1'b1;
      S_BFS_SCAN:  cmd.scan_step = !sts.cand_zero;
      S_PATH_INIT: cmd.path_init = 1'b1;
      S_PATH_CHECK: begin
        cmd.load_out = sts.out_free;
        cmd.out_pv   = sts.path_more ? PV_CUR : PV_SRC;
        cmd.out_last = !sts.path_more;
      end
      S_PATH_WAIT: cmd.path_step = sts.out_free;
      S_NOPATH: begin
        cmd.load_out   = sts.out_free;
        cmd.out_status = ST_NOPATH;
        cmd.out_last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/bpf_datapath.sv
// Datapath: adjacency memory, search queue, parent table and result register.
`include "bfs_path_finder_defines.svh"
module bpf_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   in_data,
  input  logic          cfg_write,
  input  logic [6:0]    cfg_value,
  input  bpf_pkg::cmd_t cmd,
  output bpf_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [23:0]   out_data,
  output logic          out_last
);
  import bpf_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [CNTW-1:0]   vertex_count;
  logic [CNTW-1:0]   n_eff;
  op_t               op;
  logic [VW-1:0]     src, dst;
  status_t           res_status;
  logic [TALLYW-1:0] edge_tally;

  logic [ROW_W-1:0]  adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_valid;
  logic [ROW_W-1:0]  row_rdata;
  logic              row_vld_q;
  logic [ROW_W-1:0]  row_q;
  logic              adj_rd;
  logic [AW-1:0]     adj_raddr;
  logic              adj_we;
  logic [AW-1:0]     adj_waddr;
  logic [ROW_W-1:0]  adj_wdata;
  logic [ROW_W-1:0]  edge_bit;

  logic [VW-1:0]     queue_mem [MAX_VERTICES];
  logic [VW-1:0]     queue_rdata;
  logic [VW-1:0]     parent_mem [MAX_VERTICES];
  logic [VW-1:0]     parent_rdata;
  logic [CNTW-1:0]   head, tail;
  logic [ROW_W-1:0]  dequeued, enqueued, cand, nmask;
  logic [VW-1:0]     x, y, v;
  logic [CNTW-1:0]   k;
  logic [ROW_W-1:0]  y_bit;

  logic [1:0]        st_q;
  logic [VW-1:0]     pv_q;
  logic [TALLYW-1:0] tally_q;

  always_ff @(posedge clk) begin
    if (rst)            vertex_count <= 7'd64;
    else if (cfg_write) vertex_count <= cfg_value;
  end

  assign n_eff = (vertex_count > CNTW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : vertex_count;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) nmask[i] = (CNTW'(i) < n_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= op_t'(in_data[1:0]);
      src        <= in_data[7:2];
      dst        <= in_data[13:8];
      res_status <= ({1'b0, in_data[7:2]} >= n_eff || {1'b0, in_data[13:8]} >= n_eff)
                    && (in_data[1:0] != OP_NONE) ? ST_INVALID : ST_OK;
    end
  end

  always_comb begin
    adj_rd    = cmd.edge_read_a | cmd.edge_read_b | cmd.load_x;
    adj_raddr = cmd.load_x ? queue_rdata[AW-1:0] :
                cmd.edge_read_b ? dst[AW-1:0] : src[AW-1:0];
    adj_we    = cmd.edge_write_a | cmd.edge_write_b;
    adj_waddr = cmd.edge_write_b ? dst[AW-1:0] : src[AW-1:0];
    edge_bit  = ROW_W'(1) << (cmd.edge_write_b ? src : dst);
    adj_wdata = (op == OP_INSERT) ? (row_q | edge_bit) : (row_q & ~edge_bit);
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_rd) row_rdata <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= '0;
      row_vld_q <= 1'b0;
    end else begin
      if (adj_we) adj_valid[adj_waddr] <= 1'b1;
      if (adj_rd) row_vld_q <= adj_valid[adj_raddr];
    end
  end

  assign row_q = row_vld_q ? row_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) edge_tally <= '0;
    else if (cmd.edge_write_a)
      edge_tally <= (op == OP_INSERT) ? edge_tally + 1'b1 : edge_tally - 1'b1;
  end

  assign y     = lowest_bit(cand);
  assign y_bit = ROW_W'(1) << y;

  always_ff @(posedge clk) begin
    if (cmd.bfs_init) queue_mem[0] <= src;
    else if (cmd.scan_step && y != dst && !enqueued[y] && tail < CNTW'(MAX_VERTICES))
      queue_mem[tail[AW-1:0]] <= y;
    if (cmd.deq_read) queue_rdata <= queue_mem[head[AW-1:0]];
    if (cmd.scan_step) parent_mem[y[AW-1:0]] <= x;
    if (cmd.load_out && cmd.out_pv == PV_CUR) parent_rdata <= parent_mem[v[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.bfs_init) begin
      head     <= '0;
      tail     <= CNTW'(1);
      dequeued <= '0;
      enqueued <= ROW_W'(1) << src;
    end else begin
      if (cmd.deq_read) head <= head + 1'b1;
      if (cmd.load_x) begin
        x        <= queue_rdata;
        dequeued <= dequeued | (ROW_W'(1) << queue_rdata);
      end
      if (cmd.load_cand) cand <= row_q & ~dequeued & nmask;
      if (cmd.scan_step) begin
        cand <= cand & ~y_bit;
        if (y != dst && !enqueued[y] && tail < CNTW'(MAX_VERTICES)) begin
          enqueued <= enqueued | y_bit;
          tail     <= tail + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.path_init) begin
      v <= dst;
      k <= '0;
    end else if (cmd.path_step) begin
      v <= parent_rdata;
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      st_q     <= cmd.out_status;
      tally_q  <= edge_tally;
      out_last <= cmd.out_last;
      unique case (cmd.out_pv)
        PV_CUR:  pv_q <= v;
        PV_SRC:  pv_q <= src;
        default: pv_q <= '0;
      endcase
    end
  end

  assign out_data = {4'd0, tally_q, pv_q, st_q};

  always_comb begin
    sts             = '0;
    sts.op          = op;
    sts.res_status  = res_status;
    sts.skip        = (op == OP_NONE) || (res_status == ST_INVALID);
    sts.edge_change = (op == OP_INSERT) ? !row_q[dst] : row_q[dst];
    sts.queue_ready = (head < tail) && (head < CNTW'(MAX_VERTICES));
    sts.cand_zero   = (cand == '0);
    sts.hit_dst     = (y == dst);
    sts.path_more   = (v != src) && (k < CNTW'(MAX_VERTICES - 1));
    sts.out_free    = !out_valid;
  end

  `BPF_ASSERT_ALWAYS(a_tail_bound, tail <= CNTW'(MAX_VERTICES))
  `BPF_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid)
  `BPF_ASSERT_IMPL(a_deq_order, cmd.deq_read, head < tail)
  `BPF_ASSERT_NEXT(a_tally_step, cmd.edge_write_a && op == OP_INSERT,
                   edge_tally == $past(edge_tally) + 1'b1)

endmodule

FILE: dv/bfs_path_finder_check.sv
// Scoreboard for bfs_path_finder: graph predictor and result comparison.
`timescale 1ns / 100ps
module bfs_path_finder_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          paths_found,
  output int          results_seen
);
  import bpf_pkg::*;

  typedef struct {
    status_t       status;
    logic [5:0]    vertex;
    logic [11:0]   total;
    logic          last;
  } graph_result_t;

  logic [63:0]   adj_rows [64];
  logic [11:0]   edge_count;
  logic [6:0]    vertex_limit;
  graph_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic void add_result(status_t st, logic [5:0] v, logic fin);
    graph_result_t r;
    r.status = st;
    r.vertex = v;
    r.total  = edge_count;
    r.last   = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_graph_op(op_t op, logic [5:0] a, logic [5:0] b);
    int          n;
    int          head;
    int          tail;
    int          k;
    logic [63:0] seen_deq;
    logic [63:0] seen_enq;
    logic [5:0]  parent [64];
    logic [5:0]  fifo [64];
    logic [5:0]  x;
    logic [5:0]  v;
    logic        found;
    n = (vertex_limit > 64) ? 64 : vertex_limit;
    if (op == OP_NONE) begin
      add_result(ST_OK, '0, 1'b1);
      return;
    end
    if (a >= n || b >= n) begin
      add_result(ST_INVALID, '0, 1'b1);
      return;
    end
    if (op == OP_INSERT) begin
      if (!adj_rows[a][b]) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
        edge_count = edge_count + 12'd1;
      end
      add_result(ST_OK, '0, 1'b1);
      return;
    end
    if (op == OP_REMOVE) begin
      if (adj_rows[a][b]) begin
        adj_rows[a][b] = 1'b0;
        adj_rows[b][a] = 1'b0;
        edge_count = edge_count - 12'd1;
      end
      add_result(ST_OK, '0, 1'b1);
      return;
    end
    foreach (parent[i]) parent[i] = '0;
    seen_deq = '0;
    seen_enq = 64'd1 << a;
    fifo[0] = a;
    head = 0;
    tail = 1;
    found = 1'b0;
    while (head < tail && head < 64 && !found) begin
      x = fifo[head];
      head++;
      seen_deq[x] = 1'b1;
      for (int y = 0; y < n; y++) begin
        if (!adj_rows[x][y] || seen_deq[y]) continue;
        parent[y] = x;
        if (y == b) begin
          found = 1'b1;
          break;
        end
        if (!seen_enq[y] && tail < 64) begin
          seen_enq[y] = 1'b1;
          fifo[tail] = 6'(y);
          tail++;
        end
      end
    end
    if (!found) begin
      add_result(ST_NOPATH, '0, 1'b1);
      return;
    end
    paths_found++;
    v = b;
    k = 0;
    while (v != a && k < 63) begin
      add_result(ST_OK, v, 1'b0);
      k++;
      v = parent[v];
    end
    add_result(ST_OK, a, 1'b1);
  endfunction

  always @(posedge clk) begin
    graph_result_t want;
    if (rst) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      edge_count = '0;
      vertex_limit = 7'd64;
      expected_results.delete();
      fail_count = 0;
      paths_found = 0;
      results_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[7:2] !== want.vertex) begin
            $error("path_vertex: expected %0d, got %0d", want.vertex, m_axis_tdata[7:2]);
            fail_count++;
          end
          if (m_axis_tdata[19:8] !== want.total) begin
            $error("edge_total: expected %0d, got %0d", want.total, m_axis_tdata[19:8]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) vertex_limit = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        predict_graph_op(op_t'(s_axis_tdata[1:0]), s_axis_tdata[7:2], s_axis_tdata[13:8]);
    end
  end

endmodule

FILE: dv/bfs_path_finder_test.sv
// Testbench top for bfs_path_finder: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module bfs_path_finder_test;
  import bpf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int paths_found;
  int results_seen;
  int tx_idle = 26;
  int rx_idle = 52;
  int items_sent = 0;
  int stim_limit = 64;

  int phase_counts [8] = '{8, 16, 64, 4, 1, 32, 127, 12};

  bfs_path_finder dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bfs_path_finder_check check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .paths_found(paths_found), .results_seen(results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) m_axis_tready <= !rst && ($urandom_range(0, 99) >= rx_idle);

  task automatic send_op(op_t op, logic [5:0] a, logic [5:0] b);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, a, op};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_vertex_count(logic [6:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stim_limit = (value > 64) ? 64 : value;
  endtask

  function automatic logic [5:0] pick_vertex();
    int span;
    span = (stim_limit > 12) ? 12 : stim_limit;
    if (span > 0 && $urandom_range(0, 99) < 80) return 6'($urandom_range(0, span - 1));
    if (stim_limit > 0 && $urandom_range(0, 99) < 70) return 6'($urandom_range(0, stim_limit - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 60) return OP_REMOVE;
    if (r < 95) return OP_FIND;
    return OP_NONE;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(OP_INSERT, 6'd0, 6'd63);
    send_op(OP_INSERT, 6'd63, 6'd63);
    send_op(OP_INSERT, 6'd63, 6'd0);
    send_op(OP_INSERT, 6'd5, 6'd6);
    send_op(OP_INSERT, 6'd6, 6'd7);
    send_op(OP_INSERT, 6'd7, 6'd63);
    send_op(OP_FIND, 6'd0, 6'd5);
    send_op(OP_FIND, 6'd5, 6'd5);
    send_op(OP_FIND, 6'd0, 6'd40);
    send_op(OP_REMOVE, 6'd6, 6'd5);
    send_op(OP_REMOVE, 6'd5, 6'd6);
    send_op(OP_FIND, 6'd0, 6'd5);
    send_op(OP_NONE, 6'd63, 6'd63);
    send_op(OP_NONE, 6'd0, 6'd0);
    write_vertex_count(7'd8);
    send_op(OP_INSERT, 6'd3, 6'd9);
    send_op(OP_FIND, 6'd9, 6'd2);
    send_op(OP_FIND, 6'd6, 6'd7);
    send_op(OP_FIND, 6'd0, 6'd7);
    write_vertex_count(7'd0);
    send_op(OP_INSERT, 6'd0, 6'd0);
    send_op(OP_FIND, 6'd0, 6'd0);
    write_vertex_count(7'd127);
    send_op(OP_FIND, 6'd63, 6'd0);
    send_op(OP_FIND, 6'd0, 6'd7);
    send_op(OP_REMOVE, 6'd63, 6'd63);

    for (int p = 0; p < 8; p++) begin
      write_vertex_count(7'(phase_counts[p]));
      if (p < 3) begin
        tx_idle = 26;
        rx_idle = 52;
      end else if (p < 6) begin
        tx_idle = 52;
        rx_idle = 26;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      repeat (36) send_op(pick_op(), pick_vertex(), pick_vertex());
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending != 0) $error("results still outstanding: %0d", pending);
    $display("covered %0d input transactions, %0d result transactions, %0d paths found",
             items_sent, results_seen, paths_found);
    $display("vertex counts 0, 1, 4, 8, 12, 16, 32, 64, 127 under three flow-control mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("bfs_path_finder regression: pass");
    end else begin
      $display("bfs_path_finder regression: fail");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("bfs_path_finder regression: fail");
    $finish;
  end

endmodule
